[hdl/irss_pkg.sv]
// Shared types and constants for the IR remote station selector.
// No dependencies; imported by irss_keymap and ir_remote_station_selector.
`default_nettype none

package irss_pkg;

   localparam int FRAME_W   = 12;
   localparam int STATION_W = 3;
   localparam int FREQ_W    = 10;
   localparam int TIME_W    = 8;
   localparam int STATIONS  = 8;

   localparam logic [TIME_W-1:0]  START_LOW_RESET = 8'd72;
   localparam logic [FRAME_W-1:0] CLEAR_CODE      = 12'h110;

   // Button codes for buttons one to eight, in station order.
   localparam logic [FRAME_W-1:0] BUTTON_CODE [STATIONS] = '{
      12'h010, 12'h810, 12'h410, 12'hc10, 12'h210, 12'ha10, 12'h610, 12'he10
   };

   // Frequencies in tenths of a megahertz, in station order.
   localparam logic [FREQ_W-1:0] FREQ_TABLE [STATIONS] = '{
      10'd768, 10'd774, 10'd783, 10'd789, 10'd803, 10'd809, 10'd816, 10'd822
   };

   typedef struct packed {
      logic                 hit;
      logic [STATION_W-1:0] station;
      logic [FREQ_W-1:0]    frequency;
      logic                 clear;
   } key_result_type;

endpackage

`default_nettype wire

[hdl/irss_keymap.sv]
// Maps a received button code to a station, its frequency, or a clear request.
// Depends on irss_pkg.
`default_nettype none

module irss_keymap #(
   parameter int CODE_BITS = 12
) (
   input  wire logic [CODE_BITS-1:0] code,
   output irss_pkg::key_result_type  result
);
   import irss_pkg::*;

   logic [CODE_BITS-1:0] key;

   // The lowest code bit is ignored when matching buttons.
   assign key = {code[CODE_BITS-1:1], 1'b0};

   always_comb begin
      result = '0;
      for (int i = 0; i < STATIONS; i++) begin
         if (key == CODE_BITS'(BUTTON_CODE[i])) begin
            result.hit       = 1'b1;
            result.station   = STATION_W'(i);
            result.frequency = FREQ_TABLE[i];
         end
      end
      result.clear = (key == CODE_BITS'(CLEAR_CODE));
   end

endmodule

`default_nettype wire

[hdl/ir_remote_station_selector.sv]
// Top level of the IR remote station selector: frame receiver, poll logic
// and result register. Depends on irss_pkg and irss_keymap.
`default_nettype none

// The block receives pulse-width coded remote frames as a stream of items on
// the req_ channel. An item with req_cmd low is a line edge: req_line_level
// tells the level after the edge and req_elapsed the ticks of the period that
// just ended. A rising edge after a low longer than the start_low_min
// register (csr_wr_en / csr_wr_data, reset 72) opens a frame; each further
// rising edge shifts in one bit, a one when the low time exceeds twice the
// last high time, and after CODE_BITS bits the frame is complete. An item
// with req_cmd high is a poll: on a complete frame it accepts the code when it
// matches the previous frame and differs from the last accepted code, and
// reports the station and its frequency, or a display-clear request. Every
// item yields exactly one result item on the rsp_ channel. State and the
// result register update at the edge that accepts the item, so the block
// takes one item per clock while rsp_ready is high.
// The single result register is the only buffering, so an item is accepted
// whenever that register is empty or its item is taken in the same cycle.
module ir_remote_station_selector #(
   parameter int CODE_BITS = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic                             req_cmd,
   input  wire logic                             req_line_level,
   input  wire logic [irss_pkg::TIME_W-1:0]      req_elapsed,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic                             rsp_receiving,
   output      logic [irss_pkg::FRAME_W-1:0]     rsp_frame_code,
   output      logic                             rsp_station_valid,
   output      logic [irss_pkg::STATION_W-1:0]   rsp_station,
   output      logic [irss_pkg::FREQ_W-1:0]      rsp_frequency,
   output      logic                             rsp_clear_request,
   input  wire logic                             csr_wr_en,
   input  wire logic [irss_pkg::TIME_W-1:0]      csr_wr_data
);
   import irss_pkg::*;

   localparam int CNT_W = $clog2(CODE_BITS + 1);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_DONE = 2'd2,
      PH_HOLD = 2'd3
   } phase_type;

   // Receiver state.
   phase_type            phase_ff, phase_in;
   logic [TIME_W-1:0]    low_len_ff, low_len_in;
   logic [TIME_W-1:0]    high_len_ff, high_len_in;
   logic [CNT_W-1:0]     bits_got_ff, bits_got_in;
   logic [CODE_BITS-1:0] shift_code_ff, shift_code_in;
   logic [CODE_BITS-1:0] previous_code_ff, previous_code_in;
   logic [CODE_BITS-1:0] last_accepted_ff, last_accepted_in;
   logic                 led_ff, led_in;
   logic [TIME_W-1:0]    start_low_min_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic [FRAME_W-1:0]   frame_code_ff;
   logic                 station_valid_ff, station_valid_in;
   logic [STATION_W-1:0] station_ff, station_in;
   logic [FREQ_W-1:0]    frequency_ff, frequency_in;
   logic                 clear_ff, clear_in;

   logic                 accept;
   logic                 bit_value;
   key_result_type       key_result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // A bit is a one when the low time exceeds twice the high time; the
   // doubled high time keeps its ninth bit.
   assign bit_value = {1'b0, req_elapsed} > {high_len_ff, 1'b0};

   irss_keymap #(
      .CODE_BITS(CODE_BITS)
   ) u_keymap (
      .code  (shift_code_ff),
      .result(key_result)
   );

   always_comb begin
      phase_in         = phase_ff;
      low_len_in       = low_len_ff;
      high_len_in      = high_len_ff;
      bits_got_in      = bits_got_ff;
      shift_code_in    = shift_code_ff;
      previous_code_in = previous_code_ff;
      last_accepted_in = last_accepted_ff;
      led_in           = led_ff;
      station_valid_in = 1'b0;
      station_in       = '0;
      frequency_in     = '0;
      clear_in         = 1'b0;

      if (!req_cmd) begin
         if (req_line_level) begin
            low_len_in = req_elapsed;
         end else begin
            high_len_in = req_elapsed;
         end
         if (phase_ff == PH_IDLE && req_line_level && req_elapsed > start_low_min_ff) begin
            phase_in      = PH_RECV;
            bits_got_in   = '0;
            shift_code_in = '0;
            led_in        = 1'b1;
         end else if (phase_ff == PH_RECV && req_line_level) begin
            shift_code_in = {shift_code_ff[CODE_BITS-2:0], bit_value};
            bits_got_in   = bits_got_ff + CNT_W'(1);
            if (bits_got_in == CNT_W'(CODE_BITS)) begin
               phase_in = PH_DONE;
               led_in   = 1'b0;
            end
         end
      end else if (phase_ff == PH_DONE) begin
         // A code counts only when two frames in a row agree and it is new.
         if (previous_code_ff == shift_code_ff && last_accepted_ff != shift_code_ff) begin
            last_accepted_in = shift_code_ff;
            station_valid_in = key_result.hit;
            station_in       = key_result.station;
            frequency_in     = key_result.frequency;
            clear_in         = key_result.clear;
         end
         previous_code_in = shift_code_ff;
         phase_in         = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         low_len_ff       <= '0;
         high_len_ff      <= '0;
         bits_got_ff      <= '0;
         shift_code_ff    <= '0;
         previous_code_ff <= '0;
         last_accepted_ff <= '0;
         led_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            low_len_ff       <= low_len_in;
            high_len_ff      <= high_len_in;
            bits_got_ff      <= bits_got_in;
            shift_code_ff    <= shift_code_in;
            previous_code_ff <= previous_code_in;
            last_accepted_ff <= last_accepted_in;
            led_ff           <= led_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The configuration register resets to the usual start threshold.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_min_ff <= START_LOW_RESET;
      end else if (csr_wr_en) begin
         start_low_min_ff <= csr_wr_data;
      end
   end

   // Result payload: the indicator and code show the state after the item.
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_code_ff    <= shift_code_in[FRAME_W-1:0];
         station_valid_ff <= station_valid_in;
         station_ff       <= station_in;
         frequency_ff     <= frequency_in;
         clear_ff         <= clear_in;
      end
   end

   logic receiving_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         receiving_ff <= led_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_receiving     = receiving_ff;
   assign rsp_frame_code    = frame_code_ff;
   assign rsp_station_valid = station_valid_ff;
   assign rsp_station       = station_ff;
   assign rsp_frequency     = frequency_ff;
   assign rsp_clear_request = clear_ff;

`ifndef SYNTH
   // The indicator is lit exactly while a frame is being received.
   a_led_phase: assert property (@(posedge clock) disable iff (reset)
      led_ff == (phase_ff == PH_RECV))
      else $error("indicator out of step with receive phase");

   // The bit counter never runs past the frame length.
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_got_ff <= CNT_W'(CODE_BITS))
      else $error("bit counter beyond frame length");

   // A poll on a complete frame always returns the receiver to idle.
   a_poll_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd && phase_ff == PH_DONE |=> phase_ff == PH_IDLE)
      else $error("poll did not close the frame");

   // A station selection and a clear request never come from the same item.
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(station_valid_ff && clear_ff))
      else $error("station and clear reported together");
`endif

endmodule

`default_nettype wire
